// ===== hw/rtl/circular_queue_with_prefix_reverse_defines.svh =====
// Assertion macros for the circular queue block.
// Needs clk and rst in the scope where a macro is used.
`ifndef CIRCULAR_QUEUE_WITH_PREFIX_REVERSE_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_PREFIX_REVERSE_DEFINES_SVH

// same-cycle implication
`define CQPR_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CQPR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cqpr_pkg.sv =====
// Shared types, constants and ring pointer helper for the circular queue.
// No dependencies.
package cqpr_pkg;

  localparam int DEPTH  = 256;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int SWAP_W = $clog2(DEPTH / 2 + 1);

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(DEPTH);
  localparam logic [DATA_W-1:0] NO_WORD   = '1;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_REVERSE = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_DEQ     = 9'b000000010,
    S_WALK    = 9'b000000100,
    S_SW_RA   = 9'b000001000,
    S_SW_RB   = 9'b000010000,
    S_SW_WA   = 9'b000100000,
    S_SW_WB   = 9'b001000000,
    S_RD_HEAD = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  // next slot, wrapping to 0 at the effective capacity
  function automatic logic [PTR_W-1:0] ring_adv(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [CNT_W-1:0] n;
    n = CNT_W'(p) + CNT_W'(1);
    return (n >= cap) ? '0 : n[PTR_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/cqpr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cqpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/circular_queue_with_prefix_reverse.sv =====
// Ring-buffer queue of signed 32-bit words held in one 256-entry RAM, with
// enqueue, dequeue and an in-place reverse of the oldest k entries. One beat
// in gives one result beat out; a new beat is taken only when the previous
// item is finished, while its result may still sit in the output register.
// A reverse first locates the k-th slot one step a cycle, then does each swap
// as two reads and two writes on the RAM's single read and single write port.
// No clearing pass after reset.
// Depends on cqpr_pkg, cqpr_ram and the defines header.
`include "circular_queue_with_prefix_reverse_defines.svh"

module circular_queue_with_prefix_reverse import cqpr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [CNT_W-1:0]         cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               op,
  input  logic signed [DATA_W-1:0] value,
  input  logic [CNT_W-1:0]         reverse_length,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] read_value,
  output logic [1:0]               status,
  output logic signed [DATA_W-1:0] head_value,
  output logic                     is_empty,
  output logic [CNT_W-1:0]         entry_total
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  capacity;
  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [PTR_W-1:0]  lo, lo_next;
  logic [PTR_W-1:0]  hi, hi_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic [CNT_W-1:0]  span_m1, span_m1_next;
  logic [SWAP_W-1:0] swaps_left, swaps_left_next;
  logic [DATA_W-1:0] tmp_a, tmp_a_next;
  logic [DATA_W-1:0] rd_word, rd_word_next;
  status_t           stat, stat_next;

  logic [CNT_W-1:0]  eff_cap;
  logic [PTR_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  k_clamped;
  logic              in_fire;
  logic              out_load;

  logic              ram_we;
  logic [PTR_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [PTR_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  cqpr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (capacity > DEPTH_CNT) begin
      eff_cap = DEPTH_CNT;
    end else begin
      eff_cap = capacity;
    end
  end

  assign cap_m1    = PTR_W'(eff_cap - CNT_W'(1));
  assign k_clamped = (reverse_length > count) ? count : reverse_length;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    count_next      = count;
    lo_next         = lo;
    hi_next         = hi;
    pos_next        = pos;
    span_m1_next    = span_m1;
    swaps_left_next = swaps_left;
    tmp_a_next      = tmp_a;
    rd_word_next    = rd_word;
    stat_next       = stat;
    ram_we          = 1'b0;
    ram_waddr       = tail;
    ram_wdata       = $unsigned(value);
    ram_raddr       = head;

    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          rd_word_next = NO_WORD;
          stat_next    = ST_DONE;
          state_next   = S_RD_HEAD;
          unique case (op_t'(op))
            OP_ENQUEUE: begin
              if (count >= eff_cap) begin
                stat_next = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                tail_next  = ring_adv(tail, eff_cap);
                count_next = count + CNT_W'(1);
              end
            end
            OP_DEQUEUE: begin
              if (count == '0) begin
                stat_next = ST_EMPTY;
              end else begin
                state_next = S_DEQ;
              end
            end
            OP_REVERSE: begin
              if (k_clamped > CNT_W'(1)) begin
                lo_next         = head;
                hi_next         = head;
                pos_next        = '0;
                span_m1_next    = k_clamped - CNT_W'(1);
                swaps_left_next = SWAP_W'(k_clamped >> 1);
                state_next      = S_WALK;
              end
            end
            OP_NONE: begin
            end
          endcase
        end
      end
      S_DEQ: begin
        rd_word_next = ram_rdata;
        head_next    = ring_adv(head, eff_cap);
        count_next   = count - CNT_W'(1);
        state_next   = S_RD_HEAD;
      end
      S_WALK: begin
        if (pos == span_m1) begin
          state_next = S_SW_RA;
        end else begin
          hi_next  = ring_adv(hi, eff_cap);
          pos_next = pos + CNT_W'(1);
        end
      end
      S_SW_RA: begin
        ram_raddr  = lo;
        state_next = S_SW_RB;
      end
      S_SW_RB: begin
        ram_raddr  = hi;
        tmp_a_next = ram_rdata;
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        ram_we     = 1'b1;
        ram_waddr  = lo;
        ram_wdata  = ram_rdata;
        state_next = S_SW_WB;
      end
      S_SW_WB: begin
        ram_we          = 1'b1;
        ram_waddr       = hi;
        ram_wdata       = tmp_a;
        lo_next         = ring_adv(lo, eff_cap);
        pos_next        = pos - CNT_W'(1);
        swaps_left_next = swaps_left - SWAP_W'(1);
        // step back one place in the walk; place 0 is always the head slot
        if (pos_next == '0) begin
          hi_next = head;
        end else if (hi == '0) begin
          hi_next = cap_m1;
        end else begin
          hi_next = hi - PTR_W'(1);
        end
        state_next = (swaps_left == SWAP_W'(1)) ? S_RD_HEAD : S_SW_RA;
      end
      S_RD_HEAD: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= DEPTH_CNT;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hi         <= hi_next;
    pos        <= pos_next;
    span_m1    <= span_m1_next;
    swaps_left <= swaps_left_next;
    tmp_a      <= tmp_a_next;
    rd_word    <= rd_word_next;
    stat       <= stat_next;
    if (out_load) begin
      read_value  <= $signed(rd_word);
      status      <= stat;
      head_value  <= (count == '0) ? $signed(NO_WORD) : $signed(ram_rdata);
      is_empty    <= (count == '0);
      entry_total <= count;
    end
  end

  `CQPR_ASSERT_NOW(a_count_bound, 1'b1, count <= DEPTH_CNT,
                   "entry count above ring depth")
  `CQPR_ASSERT_NOW(a_swap_pending, state == S_SW_RA, swaps_left != '0,
                   "swap started with none left")
  `CQPR_ASSERT_NEXT(a_enq_count,
                    in_fire && op == OP_ENQUEUE && count < eff_cap,
                    count == $past(count) + CNT_W'(1),
                    "enqueue beat did not raise the count")

endmodule
